// ===== sv/active_note_list_tracker_macros.svh =====
// Assertion macros for the top RTL file of the held-note list tracker.
// In synthesis the macros expand to nothing.
`ifndef ACTIVE_NOTE_LIST_TRACKER_MACROS_SVH
`define ACTIVE_NOTE_LIST_TRACKER_MACROS_SVH

`ifndef SYNTHESIS

// The expression must hold at every clock edge outside reset.
`define ANLT_ASSERT_ALWAYS(lbl, clk_s, rst_s, expr, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold in the cycle after.
`define ANLT_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ANLT_ASSERT_ALWAYS(lbl, clk_s, rst_s, expr, msg)
`define ANLT_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg)

`endif

`endif

// ===== sv/anlt_pkg.sv =====
package anlt_pkg;

	// Field widths of the event and entry transactions.
	localparam int NOTE_W    = 7;
	localparam int CHAN_W    = 4;
	localparam int ENTRY_W   = NOTE_W + CHAN_W;
	localparam int IDX_OUT_W = 4;

	// Default list depth.
	localparam int LIST_CAPACITY_DEF = 16;

	// Event opcodes.
	localparam logic OP_NOTE_OFF = 1'b0;
	localparam logic OP_NOTE_ON  = 1'b1;

	// One list entry, note in the upper bits.
	typedef struct packed {
		logic [NOTE_W-1:0] note;
		logic [CHAN_W-1:0] chan;
	} entry_t;

	// Write controls from the sequencer to the list store.
	typedef struct packed {
		logic wr_en;   // write one entry this cycle
		logic wr_key;  // write the event key, else the entry read last cycle
	} store_ctrl_t;

endpackage

// ===== sv/anlt_if.sv =====
// Event channel: one note-on or note-off per transaction.
interface anlt_event_if
	import anlt_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              op;
	logic [NOTE_W-1:0] note;
	logic [CHAN_W-1:0] channel;

	modport source (output valid, output op, output note, output channel, input ready);
	modport sink   (input valid, input op, input note, input channel, output ready);
endinterface

// Entry channel: one listed held note per transaction.
interface anlt_entry_if
	import anlt_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [NOTE_W-1:0]    entry_note;
	logic [CHAN_W-1:0]    entry_channel;
	logic [IDX_OUT_W-1:0] entry_index;
	logic                 last;

	modport source (output valid, output entry_note, output entry_channel,
		output entry_index, output last, input ready);
	modport sink   (input valid, input entry_note, input entry_channel,
		input entry_index, input last, output ready);
endinterface

// ===== sv/anlt_store.sv =====
// List store: one write port, one registered read port, and the key compare.
module anlt_store
	import anlt_pkg::*;
#(
	parameter int LIST_CAPACITY = LIST_CAPACITY_DEF,
	localparam int IDX_W = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1
) (
	input  logic             clk,
	input  store_ctrl_t      ctrl,
	input  logic [IDX_W-1:0] wr_addr,
	input  logic [IDX_W-1:0] rd_addr,
	input  entry_t           key,
	output entry_t           rd_entry,
	output logic             hit
);

	entry_t mem [0:LIST_CAPACITY-1];
	entry_t rd_data_q;

	// Write either the new key or the entry read last cycle (close-up move).
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[wr_addr] <= ctrl.wr_key ? key : rd_data_q;
		end
	end

	// Registered read, one address per cycle.
	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	// Key compare unit for the search.
	assign rd_entry = rd_data_q;
	assign hit      = (rd_data_q == key);

endmodule

// ===== sv/active_note_list_tracker.sv =====
// Each event runs as steps: a search of the listed entries for a match, then an append of a
// new note-on or, on removal, a close-up of the later entries, then emission of a changed list.
// A changed list is emitted at one entry per cycle while the entry channel is not stalled.
// The store has a single read port; no event is taken while one is in work.
// Reset: arst_n clears the list count and the sequencer; the entry store is left undefined
// and needs no clearing pass.
`include "active_note_list_tracker_macros.svh"

module active_note_list_tracker
	import anlt_pkg::*;
#(
	parameter int LIST_CAPACITY = LIST_CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	anlt_event_if.sink   events,
	anlt_entry_if.source entries
);

	localparam int IDX_W = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
	localparam int CNT_W = $clog2(LIST_CAPACITY + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DECIDE,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_EMIT_RD,
		ST_EMIT_OUT
	} state_t;

	state_t               state_q;
	logic [IDX_W-1:0]     ptr_q;
	logic [CNT_W-1:0]     count_q;
	logic                 found_q;
	logic                 op_q;
	entry_t               key_q;
	logic                 out_valid_q;
	entry_t               out_entry_q;
	logic [IDX_OUT_W-1:0] out_index_q;
	logic                 out_last_q;

	store_ctrl_t          ctrl;
	logic [IDX_W-1:0]     wr_addr;
	logic [IDX_W-1:0]     rd_addr;
	entry_t               rd_entry;
	logic                 hit;

	logic [CNT_W-1:0]     ptr_ext;
	logic [CNT_W-1:0]     ptr_nx_ext;
	logic                 in_fire;
	logic                 out_fire;
	logic                 out_load;

	anlt_store #(
		.LIST_CAPACITY(LIST_CAPACITY)
	) u_store (
		.clk      (clk),
		.ctrl     (ctrl),
		.wr_addr  (wr_addr),
		.rd_addr  (rd_addr),
		.key      (key_q),
		.rd_entry (rd_entry),
		.hit      (hit)
	);

	// Pointer arithmetic at count width.
	assign ptr_ext    = CNT_W'(ptr_q);
	assign ptr_nx_ext = ptr_ext + CNT_W'(1);

	// Handshakes.
	assign events.ready = (state_q == ST_IDLE);
	assign in_fire      = events.valid && events.ready;
	assign out_fire     = out_valid_q && entries.ready;
	assign out_load     = (state_q == ST_EMIT_OUT) && (!out_valid_q || entries.ready);

	// Store addressing and write control for each sequencer step.
	always_comb begin
		ctrl.wr_en  = 1'b0;
		ctrl.wr_key = 1'b0;
		wr_addr     = ptr_q;
		rd_addr     = ptr_q;
		unique case (state_q)
			ST_IDLE: begin
				rd_addr = '0;
			end
			ST_SEARCH, ST_SHIFT_RD: begin
				rd_addr = IDX_W'(ptr_nx_ext);
			end
			ST_DECIDE: begin
				wr_addr = IDX_W'(count_q);
				if (op_q == OP_NOTE_ON && !found_q && count_q < CNT_W'(LIST_CAPACITY)) begin
					ctrl.wr_en  = 1'b1;
					ctrl.wr_key = 1'b1;
				end
			end
			ST_SHIFT_WR: begin
				ctrl.wr_en = 1'b1;
			end
			ST_EMIT_RD: begin
				rd_addr = '0;
			end
			ST_EMIT_OUT: begin
				rd_addr = out_load ? IDX_W'(ptr_nx_ext) : ptr_q;
			end
			default: begin
				rd_addr = ptr_q;
			end
		endcase
	end

	// Sequencer: search, append or close up, then emit the list if it changed and is not empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ptr_q       <= '0;
			count_q     <= '0;
			found_q     <= 1'b0;
			op_q        <= OP_NOTE_OFF;
			key_q       <= '0;
			out_valid_q <= 1'b0;
			out_entry_q <= '0;
			out_index_q <= '0;
			out_last_q  <= 1'b0;
		end else begin
			// The output register empties when its transaction completes and
			// no new entry is loaded behind it.
			if (out_fire && !out_load) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						op_q       <= events.op;
						key_q.note <= events.note;
						key_q.chan <= events.channel;
						ptr_q      <= '0;
						found_q    <= 1'b0;
						state_q    <= (count_q == '0) ? ST_DECIDE : ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (hit) begin
						found_q <= 1'b1;
						state_q <= ST_DECIDE;
					end else if (ptr_nx_ext == count_q) begin
						state_q <= ST_DECIDE;
					end else begin
						ptr_q <= IDX_W'(ptr_nx_ext);
					end
				end
				ST_DECIDE: begin
					if (op_q == OP_NOTE_ON) begin
						if (!found_q && count_q < CNT_W'(LIST_CAPACITY)) begin
							count_q <= count_q + CNT_W'(1);
							state_q <= ST_EMIT_RD;
						end else begin
							state_q <= ST_IDLE;
						end
					end else if (!found_q) begin
						state_q <= ST_IDLE;
					end else if (ptr_nx_ext < count_q) begin
						state_q <= ST_SHIFT_RD;
					end else begin
						// Removing the final entry needs no close-up.
						count_q <= count_q - CNT_W'(1);
						state_q <= (count_q == CNT_W'(1)) ? ST_IDLE : ST_EMIT_RD;
					end
				end
				ST_SHIFT_RD: begin
					state_q <= ST_SHIFT_WR;
				end
				ST_SHIFT_WR: begin
					if (ptr_nx_ext + CNT_W'(1) < count_q) begin
						ptr_q   <= IDX_W'(ptr_nx_ext);
						state_q <= ST_SHIFT_RD;
					end else begin
						count_q <= count_q - CNT_W'(1);
						state_q <= ST_EMIT_RD;
					end
				end
				ST_EMIT_RD: begin
					ptr_q   <= '0;
					state_q <= ST_EMIT_OUT;
				end
				ST_EMIT_OUT: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						out_entry_q <= rd_entry;
						out_index_q <= IDX_OUT_W'(ptr_q);
						out_last_q  <= (ptr_nx_ext == count_q);
						if (ptr_nx_ext == count_q) begin
							state_q <= ST_IDLE;
						end else begin
							ptr_q <= IDX_W'(ptr_nx_ext);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output transaction fields.
	assign entries.valid         = out_valid_q;
	assign entries.entry_note    = out_entry_q.note;
	assign entries.entry_channel = out_entry_q.chan;
	assign entries.entry_index   = out_index_q;
	assign entries.last          = out_last_q;

	// The list never grows past its capacity.
	`ANLT_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CNT_W'(LIST_CAPACITY), "list count above capacity")

	// An accepted event blocks the next one in the cycle after.
	`ANLT_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_fire, !events.ready, "event accepted while busy")

	// The store is never written while the list is being emitted.
	`ANLT_ASSERT_ALWAYS(a_no_write_in_emit, clk, arst_n, !(state_q == ST_EMIT_OUT && ctrl.wr_en), "store written during emission")

endmodule

// ===== test/tb_active_note_list_tracker.sv =====
module tb_active_note_list_tracker;
	import anlt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Events left in the queue when idling stops on both sides.
	localparam int QUIET_TAIL = 15;
	// Cycles without any transaction before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 60;
	localparam int POOL_SIZE = 20;

	typedef struct packed {
		logic              op;
		logic [NOTE_W-1:0] note;
		logic [CHAN_W-1:0] chan;
	} note_event_t;

	typedef struct packed {
		entry_t               pair;
		logic [IDX_OUT_W-1:0] index;
		logic                 last;
	} listed_note_t;

	logic clk;
	logic arst_n;

	anlt_event_if events_if ();
	anlt_entry_if entries_if ();

	active_note_list_tracker i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.events  (events_if.sink),
		.entries (entries_if.source)
	);

	note_event_t  pending_events[$];
	listed_note_t expected_entries[$];
	entry_t       held_pairs[LIST_CAPACITY_DEF];
	int           held_count = 0;
	int           error_count = 0;
	int           send_gap = 0;
	int           stall_left = 0;
	int           idle_cycles = 0;
	entry_t       note_pool[POOL_SIZE];

	// Apply one accepted event to the local copy of the held list and queue the
	// entries that the block must emit when the list changed and is not empty.
	function automatic void track_event(logic op, logic [NOTE_W-1:0] note,
		logic [CHAN_W-1:0] chan);
		entry_t       key;
		int           pos;
		bit           changed;
		listed_note_t item;
		key.note = note;
		key.chan = chan;
		pos = held_count;
		changed = 1'b0;
		for (int i = held_count - 1; i >= 0; i--) begin
			if (held_pairs[i] == key)
				pos = i;
		end
		if (op == OP_NOTE_ON) begin
			if (pos == held_count && held_count < LIST_CAPACITY_DEF) begin
				held_pairs[held_count] = key;
				held_count++;
				changed = 1'b1;
			end
		end else if (pos < held_count) begin
			for (int i = pos; i < held_count - 1; i++)
				held_pairs[i] = held_pairs[i + 1];
			held_count--;
			changed = 1'b1;
		end
		if (changed) begin
			for (int i = 0; i < held_count; i++) begin
				item.pair  = held_pairs[i];
				item.index = IDX_OUT_W'(i);
				item.last  = (i == held_count - 1);
				expected_entries = {expected_entries, item};
			end
		end
	endfunction

	task automatic queue_event(logic op, int note, int chan);
		note_event_t ev;
		ev.op   = op;
		ev.note = NOTE_W'(note);
		ev.chan = CHAN_W'(chan);
		pending_events = {pending_events, ev};
	endtask

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Event driver: presents queued events with random bursts of idle cycles.
	always @(posedge clk) begin
		if (!arst_n) begin
			events_if.valid <= 1'b0;
		end else begin
			if (events_if.valid && events_if.ready)
				track_event(events_if.op, events_if.note, events_if.channel);
			if (!events_if.valid || events_if.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					events_if.valid <= 1'b0;
				end else if (pending_events.size() == 0) begin
					events_if.valid <= 1'b0;
				end else if (pending_events.size() > QUIET_TAIL
					&& $urandom_range(0, 4) == 0) begin
					send_gap = $urandom_range(0, 5);
					events_if.valid <= 1'b0;
				end else begin
					events_if.valid   <= 1'b1;
					events_if.op      <= pending_events[0].op;
					events_if.note    <= pending_events[0].note;
					events_if.channel <= pending_events[0].chan;
					void'(pending_events.pop_front());
				end
			end
		end
	end

	// Entry monitor: checks each entry transaction against the oldest
	// expected entry and stalls the entry channel in random bursts.
	always @(posedge clk) begin : entry_monitor
		listed_note_t want;
		if (arst_n && entries_if.valid && entries_if.ready) begin
			if (expected_entries.size() == 0) begin
				$display("%0t: unexpected entry note %0d channel %0d index %0d last %0d",
					$time, entries_if.entry_note, entries_if.entry_channel,
					entries_if.entry_index, entries_if.last);
				error_count++;
			end else begin
				want = expected_entries.pop_front();
				if (entries_if.entry_note !== want.pair.note) begin
					$display("%0t: entry_note expected %0d actual %0d", $time,
						want.pair.note, entries_if.entry_note);
					error_count++;
				end
				if (entries_if.entry_channel !== want.pair.chan) begin
					$display("%0t: entry_channel expected %0d actual %0d", $time,
						want.pair.chan, entries_if.entry_channel);
					error_count++;
				end
				if (entries_if.entry_index !== want.index) begin
					$display("%0t: entry_index expected %0d actual %0d", $time,
						want.index, entries_if.entry_index);
					error_count++;
				end
				if (entries_if.last !== want.last) begin
					$display("%0t: last expected %0d actual %0d", $time,
						want.last, entries_if.last);
					error_count++;
				end
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			entries_if.ready <= 1'b0;
		end else if (pending_events.size() > QUIET_TAIL && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 5);
			entries_if.ready <= 1'b0;
		end else begin
			entries_if.ready <= 1'b1;
		end
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if (!arst_n || (events_if.valid && events_if.ready)
			|| (entries_if.valid && entries_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_active_note_list_tracker: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Stimulus and end of run.
	initial begin
		int on_pct;
		int pick;
		arst_n            = 1'b0;
		events_if.valid   = 1'b0;
		events_if.op      = OP_NOTE_OFF;
		events_if.note    = '0;
		events_if.channel = '0;
		entries_if.ready  = 1'b0;

		// Directed part. Note-off on an empty list, then a list that becomes empty.
		queue_event(OP_NOTE_OFF, 127, 15);
		queue_event(OP_NOTE_ON, 60, 9);
		queue_event(OP_NOTE_OFF, 60, 9);
		// Field extremes, a duplicate note-on and a note-off for an unlisted pair.
		queue_event(OP_NOTE_ON, 0, 0);
		queue_event(OP_NOTE_ON, 127, 15);
		queue_event(OP_NOTE_ON, 127, 15);
		queue_event(OP_NOTE_OFF, 127, 0);
		// Fill the list, then try one more new pair while it is full.
		for (int i = 1; i <= 14; i++)
			queue_event(OP_NOTE_ON, i * 9, i);
		queue_event(OP_NOTE_ON, 64, 7);
		// Remove from the middle, the front and the back.
		queue_event(OP_NOTE_OFF, 45, 5);
		queue_event(OP_NOTE_OFF, 0, 0);
		queue_event(OP_NOTE_OFF, 126, 14);

		// Random part: pairs mostly come from a small pool so that note-offs hit
		// held notes and the list reaches full; phases lean to note-on or note-off.
		for (int i = 0; i < POOL_SIZE; i++) begin
			note_pool[i].note = NOTE_W'($urandom_range(0, 127));
			note_pool[i].chan = CHAN_W'($urandom_range(0, 15));
		end
		for (int ph = 0; ph < 4; ph++) begin
			on_pct = (ph % 2 == 0) ? 85 : 25;
			for (int k = 0; k < 19; k++) begin
				if ($urandom_range(0, 9) == 0) begin
					queue_event(1'($urandom_range(0, 1)), int'($urandom_range(0, 127)),
						int'($urandom_range(0, 15)));
				end else begin
					pick = int'($urandom_range(0, POOL_SIZE - 1));
					queue_event(($urandom_range(0, 99) < on_pct) ? OP_NOTE_ON : OP_NOTE_OFF,
						int'(note_pool[pick].note), int'(note_pool[pick].chan));
				end
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Wait until every event is accepted and every expected entry has arrived.
		@(posedge clk);
		while (pending_events.size() != 0 || events_if.valid)
			@(posedge clk);
		while (expected_entries.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("tb_active_note_list_tracker: PASS");
		else
			$display("tb_active_note_list_tracker: FAIL");
		$finish;
	end

endmodule
